// ----- src/assert_macros.svh -----
// Assertion macros shared by the chain builder RTL.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising clock edge outside reset
`define VQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vqcb assertion failed");

// Expression must never be true outside reset
`define VQ_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("vqcb forbidden condition seen");

`else

`define VQ_ASSERT(label, clk, rst_n, prop)
`define VQ_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ----- src/vqcb_pkg.sv -----
// Shared types and constants of the virtqueue request chain builder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package vqcb_pkg;

  // Default descriptor count
  localparam int QUEUE_DEPTH_DEF = 8;

  // Port widths
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 160;
  localparam int KIND_W     = 3;
  localparam int SLOT_W     = 3;
  localparam int ADDR_W     = 48;
  localparam int LEN_W      = 32;
  localparam int CNT_W      = 23;
  localparam int AVAIL_W    = 16;
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // Register reset values
  localparam logic [SIZE_W-1:0] HDR_SIZE_RST      = 7'd16;
  localparam logic [SIZE_W-1:0] STATUS_STRIDE_RST = 7'd24;

  // Descriptor flag bits
  localparam logic [1:0] F_NEXT = 2'b01;
  localparam logic [1:0] F_DEVW = 2'b10;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_DESC  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_AVAIL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FAIL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERR   = 3'd4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HDR_BASE      = 2'd0,
    CFG_HDR_SIZE      = 2'd1,
    CFG_STATUS_BASE   = 2'd2,
    CFG_STATUS_STRIDE = 2'd3
  } cfg_reg_t;

  // Which result the datapath builds
  typedef enum logic [2:0] {
    RS_HDR   = 3'd0,
    RS_DATA  = 3'd1,
    RS_STAT  = 3'd2,
    RS_AVAIL = 3'd3,
    RS_FAIL  = 3'd4,
    RS_CLR   = 3'd5,
    RS_ERR   = 3'd6
  } res_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_in;
    logic       take;
    logic [1:0] pick_sel;
    logic       calc;
    logic       emit;
    res_sel_t   sel;
    logic       last;
    logic       advance;
  } vqcb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic found;
    logic cur_bad;
    logic link_more;
    logic out_free;
  } vqcb_stat_t;

endpackage

`default_nettype wire

// ----- src/vqcb_ctrl.sv -----
// Controller FSM of the chain builder: sequences free search, result emission
// and the release walk. Depends on vqcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vqcb_ctrl #(
  parameter int QUEUE_DEPTH = vqcb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_mode,
  output logic                     in_ready,
  input  wire vqcb_pkg::vqcb_stat_t stat,
  output vqcb_pkg::vqcb_cmd_t      cmd
);
  import vqcb_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_FIND = 8'b0000_0010,
    ST_FAIL = 8'b0000_0100,
    ST_CALC = 8'b0000_1000,
    ST_EMIT = 8'b0001_0000,
    ST_RCHK = 8'b0010_0000,
    ST_RCLR = 8'b0100_0000,
    ST_RERR = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic             walk_end;

  // Walk ends on a tail descriptor or after QUEUE_DEPTH clears
  assign walk_end = !stat.link_more || (step_r == IDX_W'(QUEUE_DEPTH - 1));

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.sel   = RS_FAIL;
    unique case (state_r)
      ST_IDLE: begin
        // no accept while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load_in = 1'b1;
          cnt_nxt     = 2'd0;
          step_nxt    = '0;
          state_nxt   = in_mode ? ST_RCHK : ST_FIND;
        end
      end
      ST_FIND: begin
        if (stat.found) begin
          cmd.take     = 1'b1;
          cmd.pick_sel = cnt_r;
          if (cnt_r == 2'd2) begin
            state_nxt = ST_CALC;
          end else begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end else begin
          state_nxt = ST_FAIL;
        end
      end
      ST_FAIL: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = RS_FAIL;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        cnt_nxt   = 2'd0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          unique case (cnt_r)
            2'd0:    cmd.sel = RS_HDR;
            2'd1:    cmd.sel = RS_DATA;
            2'd2:    cmd.sel = RS_STAT;
            default: cmd.sel = RS_AVAIL;
          endcase
          if (cnt_r == 2'd3) begin
            cmd.last  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
      end
      ST_RCHK: begin
        state_nxt = stat.cur_bad ? ST_RERR : ST_RCLR;
      end
      ST_RCLR: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = RS_CLR;
          cmd.last = walk_end;
          if (walk_end) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
            step_nxt    = step_r + 1'b1;
            state_nxt   = ST_RCHK;
          end
        end
      end
      ST_RERR: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = RS_ERR;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 2'd0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/vqcb_dpath.sv -----
// Datapath of the chain builder: config registers, free map, link memory,
// avail index, address arithmetic and the output register. Depends on vqcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vqcb_dpath #(
  parameter int QUEUE_DEPTH = vqcb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [vqcb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [vqcb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic [vqcb_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire vqcb_pkg::vqcb_cmd_t                 cmd,
  output vqcb_pkg::vqcb_stat_t                     stat,
  input  wire logic                                out_tready,
  output logic                                     out_tvalid,
  output logic [vqcb_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic [vqcb_pkg::KIND_W-1:0]              out_tuser,
  output logic                                     out_tlast
);
  import vqcb_pkg::*;

  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CUR_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int PROD_W = IDX_W + SIZE_W;
  localparam int LINK_W = 2 + IDX_W;

  // Configuration registers
  logic [ADDR_W-1:0] hdr_base_r, stat_base_r;
  logic [SIZE_W-1:0] hdr_size_r, stat_stride_r;

  // Latched request
  logic              wr_r;
  logic [ADDR_W-1:0] sector_r, buf_r;
  logic [CNT_W-1:0]  count_r;
  logic [CUR_W-1:0]  cur_r;

  // Allocation state
  logic [QUEUE_DEPTH-1:0] free_r, taken_r;
  logic [IDX_W-1:0]       pick_r [0:2];
  logic [PROD_W-1:0]      hdr_off_r, stat_off_r;
  logic [AVAIL_W-1:0]     avail_r;
  logic [IDX_W-1:0]       ring_r;

  // Link memory: {flags, next}
  logic [LINK_W-1:0] link_mem [QUEUE_DEPTH];
  logic [LINK_W-1:0] link_rd_r;
  logic              link_we;
  logic [IDX_W-1:0]  link_wa;
  logic [LINK_W-1:0] link_wd;

  // Search and output build
  logic [QUEUE_DEPTH-1:0] cand;
  logic                   found;
  logic [IDX_W-1:0]       low_idx;
  logic                   cur_in_range;
  logic [AVAIL_W-1:0]     avail_inc;

  logic              out_valid_r;
  logic [KIND_W-1:0] kind_r, kind_c;
  logic [SLOT_W-1:0] slot_r, slot_c, next_r, next_c, rhead_r, rhead_c;
  logic [ADDR_W-1:0] addr_r, addr_c, rsec_r, rsec_c;
  logic [LEN_W-1:0]  len_r, len_c;
  logic [1:0]        flags_r, flags_c;
  logic [AVAIL_W-1:0] acount_r, acount_c;
  logic              rtype_r, rtype_c, last_r;

  // Descriptor index to 3-bit slot field
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] x);
    logic [CUR_W-1:0] w;
    w = CUR_W'(x);
    return w[SLOT_W-1:0];
  endfunction

  // Lowest free descriptor not yet taken
  assign cand = free_r & ~taken_r;
  always_comb begin
    found   = 1'b0;
    low_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found   = 1'b1;
        low_idx = IDX_W'(i);
      end
    end
  end

  assign cur_in_range = (CUR_W + 1)'(cur_r) < (CUR_W + 1)'(QUEUE_DEPTH);
  assign avail_inc    = avail_r + 1'b1;

  assign stat.found     = found;
  assign stat.cur_bad   = !cur_in_range || free_r[cur_r[IDX_W-1:0]];
  assign stat.link_more = link_rd_r[IDX_W];
  assign stat.out_free  = !out_valid_r || out_tready;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_base_r    <= '0;
      hdr_size_r    <= HDR_SIZE_RST;
      stat_base_r   <= '0;
      stat_stride_r <= STATUS_STRIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_HDR_BASE:      hdr_base_r    <= cfg_wdata;
        CFG_HDR_SIZE:      hdr_size_r    <= cfg_wdata[SIZE_W-1:0];
        CFG_STATUS_BASE:   stat_base_r   <= cfg_wdata;
        CFG_STATUS_STRIDE: stat_stride_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Request latch, picks, offsets, walk pointer
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      wr_r     <= in_tdata[0];
      sector_r <= in_tdata[48:1];
      count_r  <= in_tdata[71:49];
      buf_r    <= in_tdata[119:72];
      cur_r    <= CUR_W'(in_tdata[122:120]);
    end else if (cmd.advance) begin
      cur_r <= CUR_W'(link_rd_r[IDX_W-1:0]);
    end
    if (cmd.take) begin
      pick_r[cmd.pick_sel] <= low_idx;
    end
    if (cmd.calc) begin
      hdr_off_r  <= PROD_W'(pick_r[0]) * PROD_W'(hdr_size_r);
      stat_off_r <= PROD_W'(pick_r[0]) * PROD_W'(stat_stride_r);
    end
  end

  // Link memory write per emitted descriptor
  always_comb begin
    link_we = 1'b0;
    link_wa = pick_r[0];
    link_wd = '0;
    if (cmd.emit) begin
      unique case (cmd.sel)
        RS_HDR: begin
          link_we = 1'b1;
          link_wa = pick_r[0];
          link_wd = {F_NEXT, pick_r[1]};
        end
        RS_DATA: begin
          link_we = 1'b1;
          link_wa = pick_r[1];
          link_wd = {F_NEXT | (wr_r ? 2'b00 : F_DEVW), pick_r[2]};
        end
        RS_STAT: begin
          link_we = 1'b1;
          link_wa = pick_r[2];
          link_wd = {F_DEVW, {IDX_W{1'b0}}};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd_r <= link_mem[cur_r[IDX_W-1:0]];
  end

  // Free map, taken mask, avail index and ring slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r  <= '1;
      taken_r <= '0;
      avail_r <= '0;
      ring_r  <= '0;
    end else begin
      if (cmd.load_in) begin
        taken_r <= '0;
      end else if (cmd.take) begin
        taken_r[low_idx] <= 1'b1;
      end
      if (link_we) begin
        free_r[link_wa] <= 1'b0;
      end
      if (cmd.emit && cmd.sel == RS_CLR) begin
        free_r[cur_r[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.emit && cmd.sel == RS_AVAIL) begin
        avail_r <= avail_inc;
        if (avail_inc == '0 || ring_r == IDX_W'(QUEUE_DEPTH - 1)) begin
          ring_r <= '0;
        end else begin
          ring_r <= ring_r + 1'b1;
        end
      end
    end
  end

  // Result fields
  always_comb begin
    kind_c   = KIND_FAIL;
    slot_c   = '0;
    addr_c   = '0;
    len_c    = '0;
    flags_c  = '0;
    next_c   = '0;
    rhead_c  = '0;
    acount_c = '0;
    rtype_c  = 1'b0;
    rsec_c   = '0;
    unique case (cmd.sel)
      RS_HDR: begin
        kind_c  = KIND_DESC;
        slot_c  = to_slot(pick_r[0]);
        addr_c  = hdr_base_r + ADDR_W'(hdr_off_r);
        len_c   = LEN_W'(hdr_size_r);
        flags_c = F_NEXT;
        next_c  = to_slot(pick_r[1]);
        rtype_c = wr_r;
        rsec_c  = sector_r;
      end
      RS_DATA: begin
        kind_c  = KIND_DESC;
        slot_c  = to_slot(pick_r[1]);
        addr_c  = buf_r;
        len_c   = {count_r, 9'b0};
        flags_c = F_NEXT | (wr_r ? 2'b00 : F_DEVW);
        next_c  = to_slot(pick_r[2]);
      end
      RS_STAT: begin
        kind_c  = KIND_DESC;
        slot_c  = to_slot(pick_r[2]);
        addr_c  = stat_base_r + ADDR_W'(stat_off_r);
        len_c   = LEN_W'(1);
        flags_c = F_DEVW;
      end
      RS_AVAIL: begin
        kind_c   = KIND_AVAIL;
        slot_c   = to_slot(ring_r);
        rhead_c  = to_slot(pick_r[0]);
        acount_c = avail_inc;
      end
      RS_CLR: begin
        kind_c = KIND_CLEAR;
        slot_c = cur_r[SLOT_W-1:0];
      end
      RS_ERR: begin
        kind_c = KIND_ERR;
        slot_c = cur_r[SLOT_W-1:0];
      end
      default: begin
        kind_c = KIND_FAIL;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      kind_r   <= kind_c;
      slot_r   <= slot_c;
      addr_r   <= addr_c;
      len_r    <= len_c;
      flags_r  <= flags_c;
      next_r   <= next_c;
      rhead_r  <= rhead_c;
      acount_r <= acount_c;
      rtype_r  <= rtype_c;
      rsec_r   <= rsec_c;
      last_r   <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {4'b0, rsec_r, rtype_r, acount_r, rhead_r, next_r,
                       flags_r, len_r, addr_r, slot_r};

endmodule

`default_nettype wire

// ----- src/virtqueue_request_chain_builder.sv -----
// Virtqueue request chain builder: usage notes.
// Input items (in_*) carry one command: tuser = 0 submits a block request,
// tuser = 1 releases the descriptor chain starting at head_index.
// A submit takes the three lowest free descriptors and yields four output
// items: header, data and status descriptor writes, then the avail ring
// write; with fewer than three free it yields one failure item. A release
// yields one clear item per descriptor walked, then an error item at a bad one.
// out_tlast marks the final output item caused by an input item.
// Sequence: a submit runs from accept to its last item through three
// searches of the free map, one offset multiply and four emit steps;
// a release checks, then clears, each descriptor in turn, paced by the
// registered read of the link memory. One input item is worked at a time;
// in_tready returns the cycle after the last output item is registered.
// The output register lets the next input be accepted while the last item
// still waits; a stalled receiver holds the block in its emit step.
// Reset (rst_n low, synchronous) marks all descriptors free, zeroes the
// avail index and restores the register defaults; no clearing pass.
// Config writes (cfg_we) take effect at once and belong in idle time.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module virtqueue_request_chain_builder #(
  parameter int QUEUE_DEPTH = vqcb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [vqcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vqcb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // tdata: is_write[0], sector[48:1], sector_count[71:49],
  //        buffer_addr[119:72], head_index[122:120], zero pad
  input  wire logic [vqcb_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: mode
  input  wire logic                            in_tuser,
  // Result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // tdata: slot[2:0], addr[50:3], length[82:51], flags[84:83],
  //        next_slot[87:85], ring_head[90:88], avail_count[106:91],
  //        req_type[107], req_sector[155:108], zero pad
  output logic [vqcb_pkg::OUT_DATA_W-1:0]      out_tdata,
  // tuser: kind
  output logic [vqcb_pkg::KIND_W-1:0]          out_tuser,
  output logic                                 out_tlast
);
  import vqcb_pkg::*;

  vqcb_cmd_t  cmd;
  vqcb_stat_t stat;
  logic       closing_kind;

  vqcb_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mode  (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vqcb_dpath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Kinds that are always the final item of their command
  assign closing_kind = (out_tuser == KIND_FAIL) || (out_tuser == KIND_ERR) ||
                        (out_tuser == KIND_AVAIL);

  // One command in flight: no accept right after an accept
  `VQ_ASSERT(a_one_at_a_time, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready)
  // Failure, release error and avail write always close their item
  `VQ_ASSERT(a_single_last, clk, rst_n, (out_tvalid && closing_kind) |-> out_tlast)
  // No result kind beyond the defined set
  `VQ_ASSERT_NEVER(a_kind_range, clk, rst_n, out_tvalid && (out_tuser > KIND_ERR))
  // Descriptor writes never end a submit
  `VQ_ASSERT_NEVER(a_desc_not_last, clk, rst_n, out_tvalid && out_tuser == KIND_DESC && out_tlast)

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for the virtqueue request chain builder: directed and random requests.
// A built-in predictor of descriptor, ring and release results checks every output item.
// Depends on vqcb_pkg (src/vqcb_pkg.sv) and the virtqueue_request_chain_builder RTL.
`timescale 1ns / 1ps

module tb;
  import vqcb_pkg::*;

  localparam int DEPTH     = QUEUE_DEPTH_DEF;
  localparam int CHAIN     = 3;
  localparam int HOLD_CYC  = 300;
  localparam int DRAIN_CYC = 20;
  localparam int PHASE_LEN = 83;

  // One input request, as the predictor sees it
  typedef struct packed {
    logic                is_release;
    logic                is_write;
    logic [ADDR_W-1:0]   sector;
    logic [CNT_W-1:0]    sector_count;
    logic [ADDR_W-1:0]   buf_addr;
    logic [SLOT_W-1:0]   head_index;
  } vq_req_t;

  // One output item: a descriptor write, ring write, clear or error
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   addr;
    logic [LEN_W-1:0]    length;
    logic [1:0]          flags;
    logic [SLOT_W-1:0]   next_slot;
    logic [SLOT_W-1:0]   ring_head;
    logic [AVAIL_W-1:0]  avail_count;
    logic                req_type;
    logic [ADDR_W-1:0]   req_sector;
    logic                last;
  } vq_op_t;

  // Directed row: a register write or a request, with an optional typed-in result
  typedef struct {
    bit                  is_cfg;
    cfg_reg_t            reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
    vq_req_t             req;
    bit                  typed;
    logic [KIND_W-1:0]   t_kind;
    logic [SLOT_W-1:0]   t_slot;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;

  // Shadow of the queue state and registers
  logic                  desc_free  [DEPTH];
  logic [SLOT_W-1:0]     desc_next  [DEPTH];
  logic [1:0]            desc_flags [DEPTH];
  logic                  chain_head [DEPTH];
  logic [AVAIL_W-1:0]    avail_idx;
  logic [ADDR_W-1:0]     hdr_base;
  logic [SIZE_W-1:0]     hdr_size;
  logic [ADDR_W-1:0]     stat_base;
  logic [SIZE_W-1:0]     stat_stride;

  vq_op_t                pending_ops[$];
  dir_row_t              dir_rows[$];
  int                    fail_count;
  int                    tx_idle;
  int                    rx_idle;
  int                    phase_no;

  virtqueue_request_chain_builder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  // Works out the output items of one request and updates the shadow state
  function automatic void derive_ring_ops(input vq_req_t rq, input bit keep);
    int unsigned pick[CHAIN];
    int          got;
    int unsigned cur;
    logic [1:0]  fl;
    logic [SLOT_W-1:0] nx;
    vq_op_t      op;
    vq_op_t      ops[$];
    got = 0;
    if (!rq.is_release) begin
      for (int i = 0; i < DEPTH && got < CHAIN; i++)
        if (desc_free[i]) begin
          pick[got] = i;
          got++;
        end
      if (got < CHAIN) begin
        op = '0;
        op.kind = KIND_FAIL;
        ops.push_back(op);
      end else begin
        for (int i = 0; i < CHAIN; i++) desc_free[pick[i]] = 1'b0;
        chain_head[pick[0]] = 1'b1;
        desc_flags[pick[0]] = F_NEXT;
        desc_next[pick[0]]  = SLOT_W'(pick[1]);
        desc_flags[pick[1]] = F_NEXT | (rq.is_write ? 2'b00 : F_DEVW);
        desc_next[pick[1]]  = SLOT_W'(pick[2]);
        desc_flags[pick[2]] = F_DEVW;
        desc_next[pick[2]]  = '0;
        // header descriptor
        op = '0;
        op.kind       = KIND_DESC;
        op.slot       = SLOT_W'(pick[0]);
        op.addr       = hdr_base + ADDR_W'(pick[0] * hdr_size);
        op.length     = LEN_W'(hdr_size);
        op.flags      = desc_flags[pick[0]];
        op.next_slot  = desc_next[pick[0]];
        op.req_type   = rq.is_write;
        op.req_sector = rq.sector;
        ops.push_back(op);
        // data descriptor
        op = '0;
        op.kind      = KIND_DESC;
        op.slot      = SLOT_W'(pick[1]);
        op.addr      = rq.buf_addr;
        op.length    = {rq.sector_count, 9'd0};
        op.flags     = desc_flags[pick[1]];
        op.next_slot = desc_next[pick[1]];
        ops.push_back(op);
        // status descriptor, indexed by the head
        op = '0;
        op.kind   = KIND_DESC;
        op.slot   = SLOT_W'(pick[2]);
        op.addr   = stat_base + ADDR_W'(pick[0] * stat_stride);
        op.length = 1;
        op.flags  = F_DEVW;
        ops.push_back(op);
        // avail ring entry
        op = '0;
        op.kind        = KIND_AVAIL;
        op.slot        = avail_idx[SLOT_W-1:0];
        avail_idx      = avail_idx + 1'b1;
        op.ring_head   = SLOT_W'(pick[0]);
        op.avail_count = avail_idx;
        ops.push_back(op);
      end
    end else begin
      // chain walk, bounded by the queue depth
      cur = rq.head_index;
      for (int steps = 0; steps < DEPTH; steps++) begin
        op = '0;
        op.slot = SLOT_W'(cur);
        if (cur >= DEPTH || desc_free[cur]) begin
          op.kind = KIND_ERR;
          ops.push_back(op);
          break;
        end
        fl = desc_flags[cur];
        nx = desc_next[cur];
        desc_flags[cur] = '0;
        desc_next[cur]  = '0;
        desc_free[cur]  = 1'b1;
        chain_head[cur] = 1'b0;
        op.kind = KIND_CLEAR;
        ops.push_back(op);
        if (!fl[0]) break;
        cur = nx;
      end
    end
    ops[ops.size()-1].last = 1'b1;
    if (keep)
      foreach (ops[i]) pending_ops.push_back(ops[i]);
  endfunction

  // Drive one request item; predict at the edge that accepts it
  task automatic send_req(input vq_req_t rq, input bit typed,
                          input logic [KIND_W-1:0] t_kind, input logic [SLOT_W-1:0] t_slot);
    vq_op_t op;
    @(negedge clk);
    while (tx_idle != 0 && $urandom_range(0, 99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rq.is_release;
    in_tdata  <= {5'd0, rq.head_index, rq.buf_addr, rq.sector_count, rq.sector, rq.is_write};
    do @(posedge clk); while (!in_tready);
    derive_ring_ops(rq, !typed);
    if (typed) begin
      op = '0;
      op.kind = t_kind;
      op.slot = t_slot;
      op.last = 1'b1;
      pending_ops.push_back(op);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_HDR_BASE:      hdr_base    = val[ADDR_W-1:0];
      CFG_HDR_SIZE:      hdr_size    = val[SIZE_W-1:0];
      CFG_STATUS_BASE:   stat_base   = val[ADDR_W-1:0];
      CFG_STATUS_STRIDE: stat_stride = val[SIZE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Block idle: input lowered, every expected item seen, pipeline drained
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic add_req(input bit rel, input bit wr, input logic [ADDR_W-1:0] sec,
                         input logic [CNT_W-1:0] cnt, input logic [ADDR_W-1:0] baddr,
                         input logic [SLOT_W-1:0] head, input bit typed,
                         input logic [KIND_W-1:0] t_kind, input logic [SLOT_W-1:0] t_slot);
    dir_row_t row;
    row.is_cfg  = 1'b0;
    row.reg_idx = CFG_HDR_BASE;
    row.wdata   = '0;
    row.req     = {rel, wr, sec, cnt, baddr, head};
    row.typed   = typed;
    row.t_kind  = t_kind;
    row.t_slot  = t_slot;
    dir_rows.push_back(row);
  endtask

  task automatic add_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.wdata   = val;
    row.req     = '0;
    row.typed   = 1'b0;
    row.t_kind  = KIND_DESC;
    row.t_slot  = '0;
    dir_rows.push_back(row);
  endtask

  // Random request: mostly well-formed submit/release traffic, some noise
  function automatic vq_req_t random_req();
    vq_req_t rq;
    int      heads[$];
    int      inner[$];
    int      nfree;
    int      r;
    rq.is_release   = 1'b0;
    rq.is_write     = 1'($urandom);
    rq.sector       = rand48();
    rq.sector_count = CNT_W'($urandom);
    rq.buf_addr     = rand48();
    rq.head_index   = SLOT_W'($urandom);
    nfree = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (desc_free[i]) nfree++;
      else if (chain_head[i]) heads.push_back(i);
      else inner.push_back(i);
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      rq.is_release = 1'b1;
    end else if (heads.size() > 0 && (nfree < CHAIN ? r < 85 : r < 45)) begin
      rq.is_release = 1'b1;
      // now and then release from the middle of a chain
      if (inner.size() > 0 && $urandom_range(0, 9) == 0)
        rq.head_index = SLOT_W'(inner[$urandom_range(0, inner.size() - 1)]);
      else
        rq.head_index = SLOT_W'(heads[$urandom_range(0, heads.size() - 1)]);
    end
    return rq;
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    if ($urandom_range(0, 9) == 0) return SIZE_W'($urandom_range(0, 127));
    return SIZE_W'($urandom_range(1, 64));
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Output monitor: compare each accepted item with the oldest expectation
  initial begin
    vq_op_t seen;
    vq_op_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        seen.kind        = out_tuser;
        seen.slot        = out_tdata[2:0];
        seen.addr        = out_tdata[50:3];
        seen.length      = out_tdata[82:51];
        seen.flags       = out_tdata[84:83];
        seen.next_slot   = out_tdata[87:85];
        seen.ring_head   = out_tdata[90:88];
        seen.avail_count = out_tdata[106:91];
        seen.req_type    = out_tdata[107];
        seen.req_sector  = out_tdata[155:108];
        seen.last        = out_tlast;
        if (pending_ops.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected item: expected none actual kind %0d slot %0d",
                   $time, seen.kind, seen.slot);
        end else begin
          want = pending_ops.pop_front();
          check_field("kind",        64'(want.kind),        64'(seen.kind));
          check_field("slot",        64'(want.slot),        64'(seen.slot));
          check_field("addr",        64'(want.addr),        64'(seen.addr));
          check_field("length",      64'(want.length),      64'(seen.length));
          check_field("flags",       64'(want.flags),       64'(seen.flags));
          check_field("next_slot",   64'(want.next_slot),   64'(seen.next_slot));
          check_field("ring_head",   64'(want.ring_head),   64'(seen.ring_head));
          check_field("avail_count", 64'(want.avail_count), 64'(seen.avail_count));
          check_field("req_type",    64'(want.req_type),    64'(seen.req_type));
          check_field("req_sector",  64'(want.req_sector),  64'(seen.req_sector));
          check_field("last",        64'(want.last),        64'(seen.last));
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold in the last phase
  initial begin
    int hold_left;
    bit held;
    hold_left  = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_no == 3 && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (rx_idle == 0) || ($urandom_range(0, 99) >= rx_idle);
      end
    end
  end

  // Main sequence
  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_HDR_BASE;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    fail_count = 0;
    tx_idle    = 0;
    rx_idle    = 0;
    phase_no   = 0;
    for (int i = 0; i < DEPTH; i++) begin
      desc_free[i]  = 1'b1;
      desc_next[i]  = '0;
      desc_flags[i] = '0;
      chain_head[i] = 1'b0;
    end
    avail_idx   = '0;
    hdr_base    = '0;
    hdr_size    = HDR_SIZE_RST;
    stat_base   = '0;
    stat_stride = STATUS_STRIDE_RST;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table, reset register values first
    add_req(1, 0, '0, '0, '0, 3'd0, 1, KIND_ERR, 3'd0);          // release of a free head
    add_req(0, 1, '1, '1, '1, 3'd7, 0, KIND_DESC, 3'd0);         // field maxima, chain 0-1-2
    add_req(0, 0, '0, '0, '0, 3'd0, 0, KIND_DESC, 3'd0);         // read, zeros, chain 3-4-5
    add_req(0, 1, rand48(), CNT_W'($urandom), rand48(), 3'd0, 1, KIND_FAIL, 3'd0);
    add_req(1, 0, '0, '0, '0, 3'd7, 1, KIND_ERR, 3'd7);
    add_req(1, 1, '1, '1, '1, 3'd4, 0, KIND_DESC, 3'd0);         // release from mid chain
    add_req(1, 0, '0, '0, '0, 3'd3, 0, KIND_DESC, 3'd0);         // walk runs into a freed one
    add_req(0, 0, rand48(), CNT_W'($urandom), rand48(), 3'd5, 0, KIND_DESC, 3'd0);
    add_req(1, 0, '0, '0, '0, 3'd0, 0, KIND_DESC, 3'd0);
    add_req(1, 0, '0, '0, '0, 3'd3, 0, KIND_DESC, 3'd0);
    add_req(1, 0, '0, '0, '0, 3'd3, 1, KIND_ERR, 3'd3);
    // register extremes, address wrap, header size all ones, status stride zero
    add_cfg(CFG_HDR_BASE, '1);
    add_cfg(CFG_HDR_SIZE, '1);
    add_cfg(CFG_STATUS_BASE, '1);
    add_cfg(CFG_STATUS_STRIDE, '0);
    add_req(0, 1, rand48(), CNT_W'($urandom), rand48(), 3'd0, 0, KIND_DESC, 3'd0);
    add_req(0, 0, rand48(), CNT_W'($urandom), rand48(), 3'd0, 0, KIND_DESC, 3'd0);
    add_req(0, 1, rand48(), CNT_W'($urandom), rand48(), 3'd0, 1, KIND_FAIL, 3'd0);
    add_req(1, 0, rand48(), CNT_W'($urandom), rand48(), 3'd3, 0, KIND_DESC, 3'd0);
    add_req(1, 1, rand48(), CNT_W'($urandom), rand48(), 3'd0, 0, KIND_DESC, 3'd0);
    add_cfg(CFG_HDR_SIZE, 48'd0);
    add_cfg(CFG_STATUS_STRIDE, 48'd127);
    add_cfg(CFG_HDR_BASE, 48'h0000_1000_0000);
    add_cfg(CFG_STATUS_BASE, 48'hFFFF_FFFF_FF00);
    add_req(0, 0, rand48(), CNT_W'($urandom), rand48(), 3'd1, 0, KIND_DESC, 3'd0);
    add_req(0, 1, rand48(), CNT_W'($urandom), rand48(), 3'd2, 0, KIND_DESC, 3'd0);
    add_req(1, 0, '0, '0, '0, 3'd0, 0, KIND_DESC, 3'd0);
    add_req(1, 0, '0, '0, '0, 3'd3, 0, KIND_DESC, 3'd0);
    add_cfg(CFG_HDR_SIZE, 48'd64);
    add_cfg(CFG_STATUS_STRIDE, 48'd1);
    add_req(0, 1, rand48(), '1, rand48(), 3'd6, 0, KIND_DESC, 3'd0);
    add_req(1, 0, '0, '0, '0, 3'd0, 0, KIND_DESC, 3'd0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_idle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].wdata);
      end else begin
        send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].t_kind, dir_rows[i].t_slot);
      end
    end

    // Random phases: sender idles less, then more, then neither idles
    for (int ph = 1; ph <= 3; ph++) begin
      wait_idle();
      tx_idle  = (ph == 1) ? 35 : (ph == 2) ? 73 : 0;
      rx_idle  = (ph == 1) ? 73 : (ph == 2) ? 35 : 0;
      write_reg(CFG_HDR_BASE, rand48());
      write_reg(CFG_HDR_SIZE, CFG_DATA_W'(rand_size()));
      write_reg(CFG_STATUS_BASE, rand48());
      write_reg(CFG_STATUS_STRIDE, CFG_DATA_W'(rand_size()));
      phase_no = ph;
      repeat (PHASE_LEN) send_req(random_req(), 0, KIND_DESC, 3'd0);
    end

    wait_idle();
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
